// ===== rtl/core/phs_pkg.sv =====
// Shared constants and record type for the PES header scanner.
`timescale 1ns / 1ps

package phs_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int OUT_OFF_W   = 32;
  localparam int TS_W        = 33;
  localparam int IDX_W       = 9;

  // one-hot scan phase
  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_HEADER = 3'b010,
    PH_SKIP   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [OUT_OFF_W-1:0] start_offset;
    logic [OUT_OFF_W-1:0] distance_prev;
    logic [7:0]           stream_ident;
    logic [15:0]          packet_length;
    logic [7:0]           header_length;
    logic                 pts_present;
    logic [TS_W-1:0]      pts_value;
    logic                 dts_present;
    logic [TS_W-1:0]      dts_value;
  } phs_rec_t;

endpackage

// ===== rtl/core/phs_parse.sv =====
// Byte-level start code search, header capture and skip state for one byte per cycle while step_i is high.
`timescale 1ns / 1ps

module phs_parse import phs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       rec_valid_o,
  output phs_rec_t   rec_o
);

  localparam logic [IDX_W-1:0] IDX_STREAM = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_LEN_HI = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_LEN_LO = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_FLAGS  = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_HLEN   = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_PTS0   = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_DTS0   = IDX_W'(14);
  localparam logic [IDX_W:0]   HDR_FIXED  = (IDX_W+1)'(9);

  logic [OFFSET_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic [OFFSET_BITS-1:0] prev_start_r, prev_start_nxt;
  logic [OFFSET_BITS-1:0] cur_start_r, cur_start_nxt;
  logic [OFFSET_BITS-1:0] start_diff;
  logic [1:0]             zero_run_r, zero_run_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [IDX_W-1:0]       hdr_idx_r, hdr_idx_nxt;
  logic [7:0]             flags_r, flags_nxt;
  logic [7:0]             stream_id_r, stream_id_nxt;
  logic [15:0]            pkt_len_r, pkt_len_nxt;
  logic [7:0]             hdr_len_r, hdr_len_nxt;
  logic [TS_W-1:0]        pts_r, pts_nxt;
  logic [TS_W-1:0]        dts_r, dts_nxt;
  logic [IDX_W:0]         idx_inc;
  logic [IDX_W:0]         end_hdr;
  logic [IDX_W:0]         end_skip;
  logic [IDX_W:0]         need_skip;

  // index of the last header byte that must be captured
  function automatic logic [IDX_W-1:0] last_needed(input logic [7:0] flags);
    logic [IDX_W-1:0] res;
    if (flags[6]) begin
      res = IDX_W'(18);
    end else if (flags[7]) begin
      res = IDX_W'(13);
    end else begin
      res = IDX_W'(8);
    end
    return res;
  endfunction

  // fold one marker-bit timestamp byte into the accumulator
  function automatic logic [TS_W-1:0] ts_fold(input logic [TS_W-1:0] acc,
                                              input logic [2:0] k,
                                              input logic [7:0] b);
    logic [TS_W-1:0] res;
    res = acc;
    case (k)
      3'd0:    res = {b[3:1], 30'd0};
      3'd1:    res[29:22] = b;
      3'd2:    res[21:15] = b[7:1];
      3'd3:    res[14:7] = b;
      default: res[6:0] = b[7:1];
    endcase
    return res;
  endfunction

  assign start_diff = cur_start_r - prev_start_r;

  always_comb begin
    byte_pos_nxt   = byte_pos_r + OFFSET_BITS'(1);
    prev_start_nxt = prev_start_r;
    cur_start_nxt  = cur_start_r;
    zero_run_nxt   = zero_run_r;
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    flags_nxt      = flags_r;
    stream_id_nxt  = stream_id_r;
    pkt_len_nxt    = pkt_len_r;
    hdr_len_nxt    = hdr_len_r;
    pts_nxt        = pts_r;
    dts_nxt        = dts_r;
    rec_valid_o    = 1'b0;
    idx_inc        = {1'b0, hdr_idx_r} + (IDX_W+1)'(1);
    end_hdr        = '0;
    need_skip      = {1'b0, last_needed(flags_r)} + (IDX_W+1)'(1);
    end_skip       = HDR_FIXED + {2'b00, hdr_len_r};
    if (end_skip < need_skip) begin
      end_skip = need_skip;
    end

    case (phase_r)
      PH_HEADER: begin
        case (hdr_idx_r)
          IDX_STREAM: stream_id_nxt = byte_i;
          IDX_LEN_HI: pkt_len_nxt[15:8] = byte_i;
          IDX_LEN_LO: pkt_len_nxt[7:0] = byte_i;
          IDX_FLAGS:  flags_nxt = byte_i;
          IDX_HLEN:   hdr_len_nxt = byte_i;
          default: begin
            if (hdr_idx_r inside {[9:13]}) begin
              pts_nxt = ts_fold(pts_r, 3'(hdr_idx_r - IDX_PTS0), byte_i);
            end else if (hdr_idx_r inside {[14:18]}) begin
              dts_nxt = ts_fold(dts_r, 3'(hdr_idx_r - IDX_DTS0), byte_i);
            end
          end
        endcase
        if (hdr_idx_r >= IDX_HLEN && hdr_idx_r >= last_needed(flags_nxt)) begin
          rec_valid_o    = 1'b1;
          prev_start_nxt = cur_start_r;
          end_hdr        = HDR_FIXED + {2'b00, hdr_len_nxt};
          if (end_hdr > idx_inc) begin
            phase_nxt   = PH_SKIP;
            hdr_idx_nxt = idx_inc[IDX_W-1:0];
          end else begin
            phase_nxt    = PH_SEARCH;
            zero_run_nxt = 2'd0;
            hdr_idx_nxt  = '0;
          end
        end else begin
          hdr_idx_nxt = idx_inc[IDX_W-1:0];
        end
      end
      PH_SKIP: begin
        if (idx_inc >= end_skip) begin
          phase_nxt    = PH_SEARCH;
          zero_run_nxt = 2'd0;
          hdr_idx_nxt  = '0;
        end else begin
          hdr_idx_nxt = idx_inc[IDX_W-1:0];
        end
      end
      default: begin
        if (byte_i == 8'h01 && zero_run_r == 2'd2) begin
          cur_start_nxt = byte_pos_r - OFFSET_BITS'(2);
          phase_nxt     = PH_HEADER;
          hdr_idx_nxt   = IDX_STREAM;
          flags_nxt     = '0;
          stream_id_nxt = '0;
          pkt_len_nxt   = '0;
          hdr_len_nxt   = '0;
          pts_nxt       = '0;
          dts_nxt       = '0;
          zero_run_nxt  = 2'd0;
        end else if (byte_i == 8'h00) begin
          zero_run_nxt = (zero_run_r == 2'd2) ? 2'd2 : zero_run_r + 2'd1;
        end else begin
          zero_run_nxt = 2'd0;
        end
      end
    endcase

    // take the record fields before an end of stream wipes the scan state
    rec_o.start_offset  = OUT_OFF_W'(cur_start_r);
    rec_o.distance_prev = OUT_OFF_W'(start_diff);
    rec_o.stream_ident  = stream_id_nxt;
    rec_o.packet_length = pkt_len_nxt;
    rec_o.header_length = hdr_len_nxt;
    rec_o.pts_present   = flags_nxt[7];
    rec_o.pts_value     = flags_nxt[7] ? pts_nxt : '0;
    rec_o.dts_present   = flags_nxt[6];
    rec_o.dts_value     = flags_nxt[6] ? dts_nxt : '0;

    // end of stream: drop all scan state, the record above still goes out
    if (last_i) begin
      byte_pos_nxt   = '0;
      prev_start_nxt = '0;
      cur_start_nxt  = '0;
      zero_run_nxt   = 2'd0;
      phase_nxt      = PH_SEARCH;
      hdr_idx_nxt    = '0;
      flags_nxt      = '0;
      stream_id_nxt  = '0;
      pkt_len_nxt    = '0;
      hdr_len_nxt    = '0;
      pts_nxt        = '0;
      dts_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      prev_start_r <= '0;
      cur_start_r  <= '0;
      zero_run_r   <= 2'd0;
      phase_r      <= PH_SEARCH;
      hdr_idx_r    <= '0;
      flags_r      <= '0;
      stream_id_r  <= '0;
      pkt_len_r    <= '0;
      hdr_len_r    <= '0;
      pts_r        <= '0;
      dts_r        <= '0;
    end else if (step_i) begin
      byte_pos_r   <= byte_pos_nxt;
      prev_start_r <= prev_start_nxt;
      cur_start_r  <= cur_start_nxt;
      zero_run_r   <= zero_run_nxt;
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      flags_r      <= flags_nxt;
      stream_id_r  <= stream_id_nxt;
      pkt_len_r    <= pkt_len_nxt;
      hdr_len_r    <= hdr_len_nxt;
      pts_r        <= pts_nxt;
      dts_r        <= dts_nxt;
    end
  end

endmodule

// ===== rtl/core/phs_out_stage.sv =====
// Result register that holds one header record until the consumer takes it.
`timescale 1ns / 1ps

module phs_out_stage import phs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load_i,
  input  phs_rec_t rec_i,
  input  logic     ready_i,
  output logic     valid_o,
  output phs_rec_t rec_o
);

  logic     valid_r, valid_nxt;
  phs_rec_t rec_r;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && ready_i) begin
      valid_nxt = 1'b0;
    end
    if (load_i) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load_i) begin
      rec_r <= rec_i;
    end
  end

  assign valid_o = valid_r;
  assign rec_o   = rec_r;

endmodule

// ===== rtl/core/pes_header_scanner_core.sv =====
// An accepted byte waits in the input register until the parser takes it; a record it
// completes is loaded into the result register, which drives the out_ ports.
// Throughput: one byte per cycle while out_ready is high; at most one record per byte.
// A record left waiting stalls parsing; at most one more byte enters the input register
// before in_ready drops until out_ready returns.
// Reset: rst_n low clears the scan state and the valid flags of the input and result registers.
`timescale 1ns / 1ps

module pes_header_scanner_core import phs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_OFF_W-1:0] out_start_offset,
  output logic [OUT_OFF_W-1:0] out_distance_prev,
  output logic [7:0]           out_stream_ident,
  output logic [15:0]          out_packet_length,
  output logic [7:0]           out_header_length,
  output logic                 out_pts_present,
  output logic [TS_W-1:0]      out_pts_value,
  output logic                 out_dts_present,
  output logic [TS_W-1:0]      out_dts_value
);

  logic       in_v_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       advance;
  logic       rec_valid;
  phs_rec_t   rec_comb;
  phs_rec_t   rec_out;

  // parse the held byte only when a produced record has a free slot
  assign advance  = in_v_r && (!out_valid || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  phs_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (advance),
    .byte_i      (byte_r),
    .last_i      (last_r),
    .rec_valid_o (rec_valid),
    .rec_o       (rec_comb)
  );

  phs_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_i  (advance && rec_valid),
    .rec_i   (rec_comb),
    .ready_i (out_ready),
    .valid_o (out_valid),
    .rec_o   (rec_out)
  );

  assign out_start_offset  = rec_out.start_offset;
  assign out_distance_prev = rec_out.distance_prev;
  assign out_stream_ident  = rec_out.stream_ident;
  assign out_packet_length = rec_out.packet_length;
  assign out_header_length = rec_out.header_length;
  assign out_pts_present   = rec_out.pts_present;
  assign out_pts_value     = rec_out.pts_value;
  assign out_dts_present   = rec_out.dts_present;
  assign out_dts_value     = rec_out.dts_value;

endmodule

// ===== rtl/core/phs_checker.sv =====
// Port-level checks for the PES header scanner, bound to the top level.
`timescale 1ns / 1ps

module phs_checker import phs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_OFF_W-1:0] out_start_offset,
  input logic [OUT_OFF_W-1:0] out_distance_prev,
  input logic                 out_pts_present,
  input logic [TS_W-1:0]      out_pts_value,
  input logic                 out_dts_present,
  input logic [TS_W-1:0]      out_dts_value
);

  // a pending item is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the item was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_start_offset) && $stable(out_distance_prev)
      && $stable(out_pts_value) && $stable(out_dts_value))
    else $error("stalled item changed");

  a_pts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pts_present |-> out_pts_value == '0)
    else $error("PTS value nonzero without PTS flag");

  a_dts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dts_present |-> out_dts_value == '0)
    else $error("DTS value nonzero without DTS flag");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind pes_header_scanner_core phs_checker u_phs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_start_offset  (out_start_offset),
  .out_distance_prev (out_distance_prev),
  .out_pts_present   (out_pts_present),
  .out_pts_value     (out_pts_value),
  .out_dts_present   (out_dts_present),
  .out_dts_value     (out_dts_value)
);
